[sv/tpo_pkg.sv]
`timescale 1ns / 1ps
// tpo_pkg: widths, fixed-point constants and elaboration-time tables of the track point odometer
// depends on nothing; imported by track_point_odometer
package tpo_pkg;

   // field widths
   localparam int LAT_W      = 31;
   localparam int LON_W      = 32;
   localparam int ELE_W      = 21;
   localparam int TS_W       = 32;
   localparam int RADIUS_W   = 24;
   localparam int SEG_W      = 35;
   localparam int DE_W       = 22;
   localparam int DT_W       = 42;
   localparam int TOT_W      = 48;
   localparam int MAG_W      = 30;
   localparam int REQ_W      = 120;
   localparam int RSP_W      = 200;

   // fixed point: signed Q2.61
   localparam int FRAC       = 61;
   localparam int STEP_LIMIT = 60;
   localparam int TAB_DEPTH  = 64;
   localparam int CORDIC_STEPS_DEFAULT = 32;
   localparam int SQ_W       = 124;

   localparam logic signed [63:0] ONE_Q     = 64'sh2000_0000_0000_0000;
   localparam logic signed [63:0] INT64_MAX = 64'sh7fff_ffff_ffff_ffff;
   localparam logic [63:0]        E7_TO_Q   = 64'd4024455254;
   localparam logic signed [34:0] QUARTER_E7 = 35'sd900000000;
   localparam logic signed [34:0] HALF_E7    = 35'sd1800000000;
   localparam logic signed [34:0] FULL_E7    = 35'sd3600000000;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6377830;
   localparam logic [9:0]          MM_PER_M     = 10'd1000;
   localparam logic [9:0]          MS_PER_S     = 10'd1000;
   localparam logic [SEG_W-1:0]    SEG_MAX      = '1;
   localparam logic [TOT_W-1:0]    TOT_MAX      = '1;

   typedef logic [TAB_DEPTH-1:0][63:0] atan_tab_type;

   // restoring division, used only while building constants
   function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(1/n) in Q61 by the truncated Taylor series
   function automatic logic [63:0] atan_inv(input logic [63:0] n);
      logic [63:0] p;
      logic [63:0] sum;
      logic [63:0] term;
      p   = udiv(ONE_Q, n);
      sum = '0;
      for (int k = 0; k < 64; k++) begin
         if (p != '0) begin
            term = udiv(p, 64'(2 * k + 1));
            if (k % 2 == 1) sum = sum - term;
            else sum = sum + term;
            p = udiv(udiv(p, n), n);
         end
      end
      return sum;
   endfunction

   function automatic atan_tab_type build_atan_tab();
      atan_tab_type t;
      t    = '0;
      t[0] = (atan_inv(64'd5) << 2) - atan_inv(64'd239);
      for (int i = 1; i < STEP_LIMIT; i++) t[i] = atan_inv(64'd1 << i);
      return t;
   endfunction

   localparam atan_tab_type ATAN_TAB = build_atan_tab();
   localparam logic signed [63:0] QUARTER_PI = ATAN_TAB[0];
   localparam logic signed [63:0] HALF_PI_Q  = QUARTER_PI * 2;
   localparam logic signed [63:0] PI_Q       = QUARTER_PI * 4;

   // Q61 product, magnitude truncated; used while building constants
   function automatic logic signed [63:0] mulq_c(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
      logic [63:0]  ua;
      logic [63:0]  ub;
      logic [63:0]  r;
      logic [127:0] p;
      logic         neg;
      neg = a[63] ^ b[63];
      ua  = a[63] ? 64'(-a) : 64'(a);
      ub  = b[63] ? 64'(-b) : 64'(b);
      p   = {64'd0, ua} * {64'd0, ub};
      r   = (p[127:124] != '0) ? 64'(INT64_MAX) : p[124:61];
      return neg ? -$signed(r) : $signed(r);
   endfunction

   // 1/sqrt of the cordic gain product, newton steps from 0.6
   function automatic logic signed [63:0] cordic_gain_inv(input int steps);
      logic signed [63:0] prod;
      logic signed [63:0] y;
      prod = ONE_Q;
      for (int i = 0; i < STEP_LIMIT; i++) begin
         if (i < steps && 2 * i <= 62) prod = prod + (prod >>> (2 * i));
      end
      y = $signed(udiv(ONE_Q, 64'd5)) * 64'sd3;
      for (int i = 0; i < 8; i++) begin
         y = mulq_c(y, 64'sd3 * ONE_Q - mulq_c(prod, mulq_c(y, y))) >>> 1;
      end
      return y;
   endfunction

   // latitude magnitude in 1e-7 degree, saturated at 90 degrees
   function automatic logic [MAG_W-1:0] lat_mag(input logic signed [LAT_W-1:0] lat);
      logic [LAT_W-1:0] m;
      m = lat[LAT_W-1] ? LAT_W'(-lat) : LAT_W'(lat);
      return (35'(m) > QUARTER_E7) ? MAG_W'(QUARTER_E7) : m[MAG_W-1:0];
   endfunction

   // longitude difference folded to [0, 90] degrees, msb set when cos flips sign
   function automatic logic [MAG_W:0] lon_fold(input logic signed [LON_W-1:0] cur,
                                               input logic signed [LON_W-1:0] prv);
      logic signed [34:0] d;
      logic               flip;
      d = 35'(cur) - 35'(prv);
      if (d >= FULL_E7) d = d - FULL_E7;
      else if (d <= -FULL_E7) d = d + FULL_E7;
      if (d > HALF_E7) d = d - FULL_E7;
      else if (d < -HALF_E7) d = d + FULL_E7;
      if (d < 0) d = -d;
      flip = (d > QUARTER_E7);
      if (flip) d = HALF_E7 - d;
      return {flip, d[MAG_W-1:0]};
   endfunction

endpackage

[sv/track_point_odometer.sv]
`timescale 1ns / 1ps
// track_point_odometer: great-circle, climb and time deltas between consecutive track points
// depends on tpo_pkg (constants, atan table, gain and folding functions)
//
// usage
//  - req channel: one track point per request (lat/lon in 1e-7 deg, elevation cm, time s)
//  - rsp channel: one result per request, segment distance, elevation and time change,
//    running totals; rsp_tuser flags the first point (deltas zero, totals unchanged)
//  - csr channel: sphere radius in meters, always ready, write it while the block is idle
// timing
//  - a point with a predecessor goes, from accept to rsp_tvalid, through three cordic
//    rotations, one cordic vectoring pass, a bit-serial square root and eight products
//    on one 32x32 multiplier; the first point goes straight from setup to the result
//  - one point is in flight at a time; req_tready is high only when idle
// reset
//  - synchronous, active high; totals clear, no previous point, radius 6377830 m
// stall
//  - the result holds on rsp_tdata/rsp_tuser until rsp_tready; no new point meanwhile
module track_point_odometer #(
   parameter int CORDIC_STEPS = tpo_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // latitude_e7[30:0], longitude_e7[62:31], elevation_cm[83:63], timestamp_s[115:84]
   input  logic [tpo_pkg::REQ_W-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // segment_distance_mm[34:0], elevation_change_cm[56:35], time_change_ms[98:57],
   // total_distance_mm[146:99], total_time_ms[194:147]
   output logic [tpo_pkg::RSP_W-1:0]     rsp_tdata,
   // first_point[0]
   output logic [0:0]                    rsp_tuser,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tpo_pkg::RADIUS_W-1:0]  csr_data
);
   import tpo_pkg::*;

   localparam int STEPS_USED = (CORDIC_STEPS > STEP_LIMIT) ? STEP_LIMIT :
                               ((CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS);
   localparam logic signed [63:0] GAIN_INV  = cordic_gain_inv(STEPS_USED);
   localparam logic [5:0]         LAST_STEP = 6'(STEPS_USED - 1);
   localparam logic [5:0]         SQRT_LAST = 6'(FRAC);
   localparam logic [5:0]         MUL_LAST  = 6'd3;
   localparam logic [SQ_W-1:0]    SQ_ONE_INIT = SQ_W'(1) << (2 * FRAC);

   // sequencer states
   typedef enum logic [9:0] {
      ST_IDLE    = 10'b00_0000_0001,
      ST_SETUP   = 10'b00_0000_0010,
      ST_MUL     = 10'b00_0000_0100,
      ST_MUL_END = 10'b00_0000_1000,
      ST_ROT     = 10'b00_0001_0000,
      ST_ROT_END = 10'b00_0010_0000,
      ST_SQRT    = 10'b00_0100_0000,
      ST_VEC     = 10'b00_1000_0000,
      ST_FINISH  = 10'b01_0000_0000,
      ST_RESP    = 10'b10_0000_0000
   } state_type;

   // which product or rotation the shared units are working on
   typedef enum logic [2:0] {
      OP_LAT1  = 3'd0,
      OP_LAT2  = 3'd1,
      OP_LON   = 3'd2,
      OP_S1S2  = 3'd3,
      OP_C1C2  = 3'd4,
      OP_P2CD  = 3'd5,
      OP_CVCV  = 3'd6,
      OP_SCALE = 3'd7
   } op_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [5:0] cnt_ff, cnt_in;

   // current request and previous point
   logic signed [LAT_W-1:0] lat_ff, lat_in, prev_lat_ff, prev_lat_in;
   logic signed [LON_W-1:0] lon_ff, lon_in, prev_lon_ff, prev_lon_in;
   logic signed [ELE_W-1:0] ele_ff, ele_in, prev_ele_ff, prev_ele_in;
   logic [TS_W-1:0]         ts_ff, ts_in, prev_ts_ff, prev_ts_in;
   logic                    have_prev_ff, have_prev_in;
   logic [RADIUS_W-1:0]     radius_ff, radius_in;

   // angle setup
   logic [MAG_W-1:0] lat2_mag_ff, lat2_mag_in, lon_mag_ff, lon_mag_in, lat1_mag;
   logic             lat1_neg_ff, lat1_neg_in, lat2_neg_ff, lat2_neg_in;
   logic             lon_flip_ff, lon_flip_in;

   // shared multiplier
   logic [63:0]        mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic               mul_neg_ff, mul_neg_in;
   logic [127:0]       acc_ff, acc_in;
   logic [31:0]        mul_pa, mul_pb;
   logic [63:0]        mul_pp;
   logic [127:0]       mul_pp_sh;
   logic [63:0]        mq_mag;
   logic signed [63:0] mq;
   logic               ld_go;
   logic signed [63:0] ld_a, ld_b;

   // shared cordic unit
   logic signed [63:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [63:0] sh_x, sh_y, atan_val, cx, cy, cz;
   logic               vec_mode, ccw, hold;

   // trig terms and cosine sum
   logic signed [63:0] s1_ff, s1_in, c1_ff, c1_in, s2_ff, s2_in, c2_ff, c2_in;
   logic signed [63:0] cd_ff, cd_in, p1_ff, p1_in, cv_ff, cv_in;
   logic signed [63:0] cv_sum, cv_clamp, u_val, ang_clamp;

   // bit-serial square root
   logic [SQ_W-1:0] sq_x_ff, sq_x_in, sq_res_ff, sq_res_in, sq_one_ff, sq_one_in;
   logic [SQ_W-1:0] sq_t, sq_x_step, sq_res_step;
   logic            sq_ge;
   logic [61:0]     root;

   // result
   logic [SEG_W-1:0]  seg_ff, seg_in;
   logic [64:0]       seg_full;
   logic [33:0]       rad_scaled;
   logic [DE_W-1:0]   o_de_ff, o_de_in, de_val;
   logic [DT_W-1:0]   o_dt_ff, o_dt_in, dt_val;
   logic              o_first_ff, o_first_in;
   logic [TOT_W-1:0]  dist_tot_ff, dist_tot_in, time_tot_ff, time_tot_in;
   logic [TOT_W:0]    dist_sum, time_sum;

   // ports
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign csr_ready  = 1'b1;
   assign rsp_tdata  = {5'd0, time_tot_ff, dist_tot_ff, o_dt_ff, o_de_ff, seg_ff};
   assign rsp_tuser  = o_first_ff;

   // multiplier: four 32x32 partial products, a half select per counter bit
   assign mul_pa = cnt_ff[0] ? mul_a_ff[63:32] : mul_a_ff[31:0];
   assign mul_pb = cnt_ff[1] ? mul_b_ff[63:32] : mul_b_ff[31:0];
   assign mul_pp = {32'd0, mul_pa} * {32'd0, mul_pb};
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    mul_pp_sh = {64'd0, mul_pp};
         2'd3:    mul_pp_sh = {mul_pp, 64'd0};
         default: mul_pp_sh = {32'd0, mul_pp, 32'd0};
      endcase
   end
   // q61 view of the product, magnitude truncated
   assign mq_mag = (acc_ff[127:124] != '0) ? 64'(INT64_MAX) : acc_ff[124:61];
   assign mq     = mul_neg_ff ? -$signed(mq_mag) : $signed(mq_mag);

   // cordic micro-rotation, rotation mode drives z to zero, vectoring drives y to zero
   assign sh_x     = x_ff >>> cnt_ff;
   assign sh_y     = y_ff >>> cnt_ff;
   assign atan_val = $signed(ATAN_TAB[cnt_ff]);
   assign vec_mode = (state_ff == ST_VEC);
   assign ccw      = vec_mode ? y_ff[63] : ~z_ff[63];
   assign hold     = vec_mode && (y_ff == '0);
   always_comb begin
      if (hold) begin
         cx = x_ff;
         cy = y_ff;
         cz = z_ff;
      end else if (ccw) begin
         cx = x_ff - sh_y;
         cy = y_ff + sh_x;
         cz = z_ff - atan_val;
      end else begin
         cx = x_ff + sh_y;
         cy = y_ff - sh_x;
         cz = z_ff + atan_val;
      end
   end

   // cosine sum clamp, 1 - c^2, final angle clamp
   assign cv_sum    = p1_ff + mq;
   assign cv_clamp  = (cv_sum > ONE_Q) ? ONE_Q : ((cv_sum < -ONE_Q) ? -ONE_Q : cv_sum);
   assign u_val     = ONE_Q - mq;
   assign ang_clamp = cz[63] ? 64'sd0 : ((cz > PI_Q) ? PI_Q : cz);

   // square root digit step
   assign sq_t        = sq_res_ff + sq_one_ff;
   assign sq_ge       = (sq_x_ff >= sq_t);
   assign sq_x_step   = sq_ge ? (sq_x_ff - sq_t) : sq_x_ff;
   assign sq_res_step = sq_ge ? ((sq_res_ff >> 1) + sq_one_ff) : (sq_res_ff >> 1);
   assign root        = sq_res_step[61:0];

   // distance scaling and rounding
   assign rad_scaled = 34'(radius_ff) * 34'(MM_PER_M);
   assign seg_full   = {1'b0, acc_ff[124:61]} + 65'(acc_ff[60]);

   // deltas and saturating totals
   assign lat1_mag = lat_mag(lat_ff);
   assign de_val   = DE_W'(ele_ff) - DE_W'(prev_ele_ff);
   assign dt_val   = (ts_ff > prev_ts_ff) ? (DT_W'(ts_ff - prev_ts_ff) * DT_W'(MS_PER_S))
                                          : '0;
   assign dist_sum = (TOT_W + 1)'(dist_tot_ff) + (TOT_W + 1)'(seg_ff);
   assign time_sum = (TOT_W + 1)'(time_tot_ff) + (TOT_W + 1)'(dt_val);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      lat_in       = lat_ff;
      lon_in       = lon_ff;
      ele_in       = ele_ff;
      ts_in        = ts_ff;
      prev_lat_in  = prev_lat_ff;
      prev_lon_in  = prev_lon_ff;
      prev_ele_in  = prev_ele_ff;
      prev_ts_in   = prev_ts_ff;
      have_prev_in = have_prev_ff;
      radius_in    = csr_valid ? csr_data : radius_ff;
      lat2_mag_in  = lat2_mag_ff;
      lon_mag_in   = lon_mag_ff;
      lat1_neg_in  = lat1_neg_ff;
      lat2_neg_in  = lat2_neg_ff;
      lon_flip_in  = lon_flip_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      mul_neg_in   = mul_neg_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      s1_in        = s1_ff;
      c1_in        = c1_ff;
      s2_in        = s2_ff;
      c2_in        = c2_ff;
      cd_in        = cd_ff;
      p1_in        = p1_ff;
      cv_in        = cv_ff;
      sq_x_in      = sq_x_ff;
      sq_res_in    = sq_res_ff;
      sq_one_in    = sq_one_ff;
      seg_in       = seg_ff;
      o_de_in      = o_de_ff;
      o_dt_in      = o_dt_ff;
      o_first_in   = o_first_ff;
      dist_tot_in  = dist_tot_ff;
      time_tot_in  = time_tot_ff;
      ld_go        = 1'b0;
      ld_a         = '0;
      ld_b         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               lat_in   = req_tdata[30:0];
               lon_in   = req_tdata[62:31];
               ele_in   = req_tdata[83:63];
               ts_in    = req_tdata[115:84];
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            lat2_mag_in               = lat_mag(prev_lat_ff);
            lat1_neg_in               = lat_ff[LAT_W-1];
            lat2_neg_in               = prev_lat_ff[LAT_W-1];
            {lon_flip_in, lon_mag_in} = lon_fold(lon_ff, prev_lon_ff);
            if (!have_prev_ff) begin
               state_in = ST_FINISH;
            end else begin
               ld_go = 1'b1;
               ld_a  = 64'(lat1_mag);
               ld_b  = E7_TO_Q;
               op_in = OP_LAT1;
            end
         end
         ST_MUL: begin
            acc_in = ((cnt_ff == '0) ? 128'd0 : acc_ff) + mul_pp_sh;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == MUL_LAST) state_in = ST_MUL_END;
         end
         ST_MUL_END: begin
            case (op_ff)
               OP_LAT1, OP_LAT2, OP_LON: begin
                  // degree-to-radian product is already q61
                  x_in     = GAIN_INV;
                  y_in     = '0;
                  z_in     = $signed(acc_ff[63:0]);
                  cnt_in   = '0;
                  state_in = ST_ROT;
               end
               OP_S1S2: begin
                  p1_in = mq;
                  ld_go = 1'b1;
                  ld_a  = c1_ff;
                  ld_b  = c2_ff;
                  op_in = OP_C1C2;
               end
               OP_C1C2: begin
                  ld_go = 1'b1;
                  ld_a  = mq;
                  ld_b  = cd_ff;
                  op_in = OP_P2CD;
               end
               OP_P2CD: begin
                  cv_in = cv_clamp;
                  ld_go = 1'b1;
                  ld_a  = cv_clamp;
                  ld_b  = cv_clamp;
                  op_in = OP_CVCV;
               end
               OP_CVCV: begin
                  sq_x_in   = u_val[63] ? '0 : {1'b0, u_val[61:0], {FRAC{1'b0}}};
                  sq_res_in = '0;
                  sq_one_in = SQ_ONE_INIT;
                  cnt_in    = '0;
                  state_in  = ST_SQRT;
               end
               OP_SCALE: begin
                  seg_in   = (seg_full > 65'(SEG_MAX)) ? SEG_MAX : seg_full[SEG_W-1:0];
                  state_in = ST_FINISH;
               end
               default: state_in = ST_FINISH;
            endcase
         end
         ST_ROT: begin
            x_in   = cx;
            y_in   = cy;
            z_in   = cz;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == LAST_STEP) state_in = ST_ROT_END;
         end
         ST_ROT_END: begin
            case (op_ff)
               OP_LAT1: begin
                  c1_in = x_ff;
                  s1_in = lat1_neg_ff ? -y_ff : y_ff;
                  ld_go = 1'b1;
                  ld_a  = 64'(lat2_mag_ff);
                  ld_b  = E7_TO_Q;
                  op_in = OP_LAT2;
               end
               OP_LAT2: begin
                  c2_in = x_ff;
                  s2_in = lat2_neg_ff ? -y_ff : y_ff;
                  ld_go = 1'b1;
                  ld_a  = 64'(lon_mag_ff);
                  ld_b  = E7_TO_Q;
                  op_in = OP_LON;
               end
               OP_LON: begin
                  cd_in = lon_flip_ff ? -x_ff : x_ff;
                  ld_go = 1'b1;
                  ld_a  = s1_ff;
                  ld_b  = s2_ff;
                  op_in = OP_S1S2;
               end
               default: state_in = ST_FINISH;
            endcase
         end
         ST_SQRT: begin
            sq_x_in   = sq_x_step;
            sq_res_in = sq_res_step;
            sq_one_in = sq_one_ff >> 2;
            cnt_in    = cnt_ff + 6'd1;
            if (cnt_ff == SQRT_LAST) begin
               // acos start vector, pre-rotated by pi/2 for a negative cosine
               if (cv_ff[63]) begin
                  x_in = $signed({2'b00, root});
                  y_in = -cv_ff;
                  z_in = HALF_PI_Q;
               end else begin
                  x_in = cv_ff;
                  y_in = $signed({2'b00, root});
                  z_in = '0;
               end
               cnt_in   = '0;
               state_in = ST_VEC;
            end
         end
         ST_VEC: begin
            x_in   = cx;
            y_in   = cy;
            z_in   = cz;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == LAST_STEP) begin
               ld_go = 1'b1;
               ld_a  = ang_clamp;
               ld_b  = 64'(rad_scaled);
               op_in = OP_SCALE;
            end
         end
         ST_FINISH: begin
            if (have_prev_ff) begin
               o_de_in     = de_val;
               o_dt_in     = dt_val;
               o_first_in  = 1'b0;
               dist_tot_in = dist_sum[TOT_W] ? TOT_MAX : dist_sum[TOT_W-1:0];
               time_tot_in = time_sum[TOT_W] ? TOT_MAX : time_sum[TOT_W-1:0];
            end else begin
               seg_in     = '0;
               o_de_in    = '0;
               o_dt_in    = '0;
               o_first_in = 1'b1;
            end
            have_prev_in = 1'b1;
            prev_lat_in  = lat_ff;
            prev_lon_in  = lon_ff;
            prev_ele_in  = ele_ff;
            prev_ts_in   = ts_ff;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // start a product: magnitudes into the multiplier, sign kept aside
      if (ld_go) begin
         mul_a_in   = ld_a[63] ? 64'(-ld_a) : 64'(ld_a);
         mul_b_in   = ld_b[63] ? 64'(-ld_b) : 64'(ld_b);
         mul_neg_in = ld_a[63] ^ ld_b[63];
         cnt_in     = '0;
         state_in   = ST_MUL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_prev_ff <= 1'b0;
         dist_tot_ff  <= '0;
         time_tot_ff  <= '0;
         radius_ff    <= RADIUS_RESET;
      end else begin
         state_ff     <= state_in;
         have_prev_ff <= have_prev_in;
         dist_tot_ff  <= dist_tot_in;
         time_tot_ff  <= time_tot_in;
         radius_ff    <= radius_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      cnt_ff      <= cnt_in;
      lat_ff      <= lat_in;
      lon_ff      <= lon_in;
      ele_ff      <= ele_in;
      ts_ff       <= ts_in;
      prev_lat_ff <= prev_lat_in;
      prev_lon_ff <= prev_lon_in;
      prev_ele_ff <= prev_ele_in;
      prev_ts_ff  <= prev_ts_in;
      lat2_mag_ff <= lat2_mag_in;
      lon_mag_ff  <= lon_mag_in;
      lat1_neg_ff <= lat1_neg_in;
      lat2_neg_ff <= lat2_neg_in;
      lon_flip_ff <= lon_flip_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      mul_neg_ff  <= mul_neg_in;
      acc_ff      <= acc_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      s1_ff       <= s1_in;
      c1_ff       <= c1_in;
      s2_ff       <= s2_in;
      c2_ff       <= c2_in;
      cd_ff       <= cd_in;
      p1_ff       <= p1_in;
      cv_ff       <= cv_in;
      sq_x_ff     <= sq_x_in;
      sq_res_ff   <= sq_res_in;
      sq_one_ff   <= sq_one_in;
      seg_ff      <= seg_in;
      o_de_ff     <= o_de_in;
      o_dt_ff     <= o_dt_in;
      o_first_ff  <= o_first_in;
   end

`ifndef NO_ASSERTIONS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_SETUP))
      else $error("accepted request did not start setup");

   a_first_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[98:0] == '0))
      else $error("first point result has nonzero deltas");

   a_rot_count: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ROT) || (state_ff == ST_VEC)) |-> (cnt_ff <= LAST_STEP))
      else $error("cordic counter ran past last step");

   a_prev_kept: assert property (@(posedge clock) disable iff (reset)
      have_prev_ff |=> have_prev_ff)
      else $error("previous point lost without reset");
`endif

endmodule
